[hw/rtl/lz77_tuple_decoder_defines.svh]
// ----------------------------------------------------------------------------
// LZ77 tuple decoder assertion macros
// Concurrent assertion wrappers shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef LZ77_TUPLE_DECODER_DEFINES_SVH
`define LZ77_TUPLE_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LZTD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
`define LZTD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LZTD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define LZTD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

[hw/rtl/lz77td_pkg.sv]
// ----------------------------------------------------------------------------
// LZ77 tuple decoder package
// Word types, microcode format and the control program of the decoder.
// ----------------------------------------------------------------------------
package lz77td_pkg;

  localparam int unsigned WINDOW_DEF = 4096;
  localparam int unsigned MAX_COPY   = 63;
  localparam int unsigned DIST_W     = 12;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned SIZE_W     = 24;
  localparam logic [SIZE_W-1:0] SIZE_RESET = '1;

  typedef struct packed {
    logic [DIST_W-1:0] back_distance;
    logic [LEN_W-1:0]  copy_length;
    logic [7:0]        literal_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       error;
  } out_word_t;

  typedef logic [2:0] step_t;

  localparam step_t S_WAIT  = 3'd0;
  localparam step_t S_CHECK = 3'd1;
  localparam step_t S_CHK2  = 3'd2;
  localparam step_t S_ERR   = 3'd3;
  localparam step_t S_RD    = 3'd4;
  localparam step_t S_COPY  = 3'd5;
  localparam step_t S_LIT   = 3'd6;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ERR,
    EMIT_COPY,
    EMIT_LIT
  } emit_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_TAKE,
    COND_BAD,
    COND_NOLEN,
    COND_MORE
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  ld_src;
    logic  rd_hist;
    emit_t emit;
    cond_t cond;
    step_t target;
    step_t next;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '0;
    w.emit = EMIT_NONE;
    w.cond = COND_NONE;
    w.target = S_WAIT;
    w.next = S_WAIT;
    unique case (step)
      S_WAIT: begin
        w.take_in = 1'b1;
        w.cond = COND_TAKE;
        w.target = S_CHECK;
        w.next = S_WAIT;
      end
      S_CHECK: begin
        w.cond = COND_BAD;
        w.target = S_ERR;
        w.next = S_CHK2;
      end
      S_CHK2: begin
        w.ld_src = 1'b1;
        w.cond = COND_NOLEN;
        w.target = S_LIT;
        w.next = S_RD;
      end
      S_ERR: begin
        w.emit = EMIT_ERR;
        w.next = S_WAIT;
      end
      S_RD: begin
        w.rd_hist = 1'b1;
        w.next = S_COPY;
      end
      S_COPY: begin
        w.emit = EMIT_COPY;
        w.cond = COND_MORE;
        w.target = S_RD;
        w.next = S_LIT;
      end
      S_LIT: begin
        w.emit = EMIT_LIT;
        w.next = S_WAIT;
      end
      default: begin
        w.next = S_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/lz77td_ram.sv]
// ----------------------------------------------------------------------------
// LZ77 tuple decoder RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lz77td_ram
  import lz77td_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = WINDOW_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/lz77_tuple_decoder.sv]
// An accepted tuple is checked and then either rejected with an error word or, after a
// length check, its copied words follow, each read from history in its own step before
// it is emitted, and the literal comes after the last copied word.
// A new tuple is taken only once the previous one has emitted its last word; the
// history RAM is read and written once per copied byte.
// Reset clears the byte count, write pointer and output valid and sets the size limit to all ones; history is kept.
// ----------------------------------------------------------------------------
// LZ77 tuple decoder
// Microcoded sequencer that expands distance, length and literal tuples into
// output bytes through a circular history RAM.
// ----------------------------------------------------------------------------
`include "lz77_tuple_decoder_defines.svh"

module lz77_tuple_decoder
  import lz77td_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              cfg_write_en,
  input  logic [SIZE_W-1:0] cfg_write_data
);

  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned DW = AW + 1;

  step_t             pc;
  in_word_t          tuple;
  logic [LEN_W-1:0]  cnt;
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     src_ptr;
  logic [SIZE_W-1:0] bytes_written;
  logic [SIZE_W-1:0] expected_size;

  ucode_t            uc;
  logic              slot_free;
  logic              adv;
  logic              in_take;
  logic              bad;
  logic              cond_true;
  logic [SIZE_W:0]   need_sum;
  logic [DW-1:0]     dist_w;
  logic [DW-1:0]     wr_wide;
  logic [AW-1:0]     src_calc;
  logic              ram_wr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  out_word_t         emit_word;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (p == AW'(WINDOW - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  assign uc        = ucode_rom(pc);
  assign slot_free = !out_valid || !out_stall;
  assign adv       = (uc.emit == EMIT_NONE) || slot_free;
  assign in_stall  = !uc.take_in;
  assign in_take   = in_valid && uc.take_in;

  assign need_sum = {1'b0, bytes_written} + (SIZE_W + 1)'(tuple.copy_length)
                  + (SIZE_W + 1)'(1);

  always_comb begin
    bad = (32'(tuple.copy_length) > MAX_COPY)
       || ((tuple.copy_length != '0)
           && ((tuple.back_distance == '0)
               || (SIZE_W'(tuple.back_distance) > bytes_written)
               || (32'(tuple.back_distance) > WINDOW)))
       || (need_sum > {1'b0, expected_size});
  end

  always_comb begin
    unique case (uc.cond)
      COND_NONE:  cond_true = 1'b0;
      COND_TAKE:  cond_true = in_take;
      COND_BAD:   cond_true = bad;
      COND_NOLEN: cond_true = (tuple.copy_length == '0);
      COND_MORE:  cond_true = (cnt != LEN_W'(1));
      default:    cond_true = 1'b0;
    endcase
  end

  assign dist_w  = DW'(tuple.back_distance);
  assign wr_wide = {1'b0, wr_ptr};

  always_comb begin
    if (wr_wide >= dist_w) begin
      src_calc = AW'(wr_wide - dist_w);
    end else begin
      src_calc = AW'(wr_wide + DW'(WINDOW) - dist_w);
    end
  end

  always_comb begin
    unique case (uc.emit)
      EMIT_ERR:  emit_word = '{data_byte: 8'h00, last: 1'b1, error: 1'b1};
      EMIT_COPY: emit_word = '{data_byte: ram_rdata, last: 1'b0, error: 1'b0};
      EMIT_LIT:  emit_word = '{data_byte: tuple.literal_byte, last: 1'b1, error: 1'b0};
      default:   emit_word = '{data_byte: 8'h00, last: 1'b0, error: 1'b0};
    endcase
  end

  assign ram_wr    = adv && ((uc.emit == EMIT_COPY) || (uc.emit == EMIT_LIT));
  assign ram_wdata = (uc.emit == EMIT_LIT) ? tuple.literal_byte : ram_rdata;

  lz77td_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (wr_ptr),
    .wr_data (ram_wdata),
    .rd_en   (uc.rd_hist),
    .rd_addr (src_ptr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= S_WAIT;
      wr_ptr        <= '0;
      bytes_written <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (adv) begin
        pc <= cond_true ? uc.target : uc.next;
      end
      if (ram_wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (adv && (uc.emit == EMIT_LIT)) begin
        bytes_written <= SIZE_W'(need_sum);
      end
      if ((uc.emit != EMIT_NONE) && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_size <= SIZE_RESET;
    end else if (cfg_write_en) begin
      expected_size <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tuple <= in_word;
      cnt   <= in_word.copy_length;
    end
    if (uc.ld_src) begin
      src_ptr <= src_calc;
    end else if (uc.rd_hist) begin
      src_ptr <= ptr_inc(src_ptr);
    end
    if (adv && (uc.emit == EMIT_COPY)) begin
      cnt <= cnt - LEN_W'(1);
    end
    if ((uc.emit != EMIT_NONE) && slot_free) begin
      out_word <= emit_word;
    end
  end

  `LZTD_ASSERT_NEXT(a_take_then_check, clk, rst, in_valid && !in_stall, pc == S_CHECK,
    "Accepted tuple did not move the sequencer to the check step.")
  `LZTD_ASSERT_IMP(a_copy_count, clk, rst, pc == S_COPY, cnt != '0,
    "Copy step reached with no bytes left to copy.")
  `LZTD_ASSERT_IMP(a_error_word, clk, rst, out_valid && out_word.error,
    out_word.last && (out_word.data_byte == 8'h00),
    "Error word must be a zero byte marked last.")

endmodule

[test/decode_check_pkg.sv]
// ----------------------------------------------------------------------------
// LZ77 tuple decoder byte stream check
// Expands accepted tuples into the bytes the decoder should emit and compares
// every emitted word against the oldest byte still awaited.
// ----------------------------------------------------------------------------
package decode_check_pkg;

  import lz77td_pkg::*;

  class byte_stream_model;
    logic [7:0]        history [WINDOW_DEF];
    logic [SIZE_W-1:0] written;
    logic [SIZE_W-1:0] size_limit;
    out_word_t         awaited [$];
    int                failures;
    int                shown;

    function new();
      written    = '0;
      size_limit = SIZE_RESET;
      failures   = 0;
      shown      = 0;
    endfunction

    function void expand_tuple(in_word_t w);
      int unsigned distance;
      int unsigned len;
      int unsigned pos;
      int unsigned src;
      out_word_t   o;
      distance = 32'(w.back_distance);
      len      = 32'(w.copy_length);
      pos      = 32'(written);
      if (len > MAX_COPY ||
          (len != 0 && (distance == 0 || distance > pos || distance > WINDOW_DEF)) ||
          pos + len + 1 > 32'(size_limit)) begin
        o.data_byte = 8'h00;
        o.last      = 1'b1;
        o.error     = 1'b1;
        awaited = {awaited, o};
        return;
      end
      src = pos - distance;
      for (int unsigned j = 0; j < len; j++) begin
        o.data_byte = history[(src + j) % WINDOW_DEF];
        o.last      = 1'b0;
        o.error     = 1'b0;
        history[(pos + j) % WINDOW_DEF] = o.data_byte;
        awaited = {awaited, o};
      end
      history[(pos + len) % WINDOW_DEF] = w.literal_byte;
      o.data_byte = w.literal_byte;
      o.last      = 1'b1;
      o.error     = 1'b0;
      awaited = {awaited, o};
      written = SIZE_W'(pos + len + 1);
    endfunction

    function void check_byte(out_word_t got);
      out_word_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (shown < 10) begin
          shown++;
          $display("unexpected word: byte %02h last %b error %b",
                   got.data_byte, got.last, got.error);
        end
        return;
      end
      want = awaited.pop_front();
      if (got.data_byte !== want.data_byte || got.last !== want.last ||
          got.error !== want.error) begin
        failures++;
        if (shown < 10) begin
          shown++;
          $display("word mismatch: expected %02h/%b/%b, got %02h/%b/%b",
                   want.data_byte, want.last, want.error,
                   got.data_byte, got.last, got.error);
        end
      end
    endfunction
  endclass

endpackage

[test/testbench.sv]
// ----------------------------------------------------------------------------
// LZ77 tuple decoder testbench
// Sends directed and random tuples under random idling on both channels,
// changes the size limit between phases and checks every output word.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import lz77td_pkg::*;
  import decode_check_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_word;
  logic              cfg_write_en = 1'b0;
  logic [SIZE_W-1:0] cfg_write_data = '0;

  byte_stream_model sb;
  bit               calm = 1'b0;
  int               idle_cycles = 0;

  lz77_tuple_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_word_t tuple(input int unsigned distance, input int unsigned len,
                                     input int unsigned lit);
    in_word_t w;
    w.back_distance = distance[DIST_W-1:0];
    w.copy_length   = len[LEN_W-1:0];
    w.literal_byte  = lit[7:0];
    return w;
  endfunction

  function automatic in_word_t random_tuple();
    in_word_t    w;
    int unsigned reach;
    int unsigned pick;
    reach = (32'(sb.written) > 4095) ? 4095 : 32'(sb.written);
    pick = $urandom_range(0, 99);
    w.literal_byte  = 8'($urandom_range(0, 255));
    w.back_distance = 12'($urandom_range(0, 4095));
    w.copy_length   = '0;
    if (pick >= 88) begin
      w.copy_length = 6'($urandom_range(0, 63));
    end else if (pick >= 12 && reach != 0) begin
      w.copy_length = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(1, 63))
                                                  : 6'($urandom_range(1, 16));
      case (pick % 4)
        0: w.back_distance = 12'($urandom_range(1, (reach < 4) ? reach : 4));
        1: w.back_distance = 12'(reach);
        default: w.back_distance = 12'($urandom_range(1, reach));
      endcase
    end
    return w;
  endfunction

  task automatic send_tuple(input in_word_t w);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.expand_tuple(w);
  endtask

  task automatic stop_tuples();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size_limit(input logic [SIZE_W-1:0] limit);
    stop_tuples();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= limit;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    sb.size_limit = limit;
  endtask

  initial begin
    int n;
    wait (!rst);
    @(posedge clk);
    forever begin
      n = idle_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_byte(out_word);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [SIZE_W-1:0] limit;
    int                count;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_tuple(tuple(3, 2, 8'h00));
    send_tuple(tuple(0, 0, 8'hFF));
    send_tuple(tuple(4095, 0, 8'h00));
    send_tuple(tuple(0, 1, 8'h11));
    send_tuple(tuple(2, 63, 8'hA5));
    send_tuple(tuple(1, 5, 8'h3C));
    send_tuple(tuple(32'(sb.written), 7, 8'hC3));
    send_tuple(tuple(32'(sb.written) + 1, 1, 8'h77));
    send_tuple(tuple(1, 63, 8'h0F));
    send_tuple(tuple(4095, 0, 8'h5A));

    set_size_limit(SIZE_W'(32'(sb.written) + 5));
    send_tuple(tuple(1, 4, 8'h96));
    send_tuple(tuple(0, 0, 8'h69));
    send_tuple(tuple(4095, 0, 8'hF0));

    set_size_limit('0);
    send_tuple(tuple(0, 0, 8'h81));
    send_tuple(tuple(4095, 63, 8'h7E));

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        1: limit = SIZE_W'(32'(sb.written) + $urandom_range(0, 400));
        2: limit = '0;
        4: limit = SIZE_W'($urandom_range(0, 24'hFFFFFF));
        5: limit = SIZE_W'(32'(sb.written) + $urandom_range(200, 1500));
        default: limit = SIZE_RESET;
      endcase
      set_size_limit(limit);
      calm = (phase == 3);
      count = (phase == 2) ? 12 : 42;
      repeat (count) send_tuple(random_tuple());
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
